// ===== hw/rtl/tone_pattern_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// Tone pattern sequencer assertion macros
// Shared property wrappers for the sequencer checkers.
// ----------------------------------------------------------------------------
`ifndef TONE_PATTERN_SEQUENCER_ASSERT_SVH
`define TONE_PATTERN_SEQUENCER_ASSERT_SVH

// check a property while out of reset
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define TPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// Tone pattern sequencer package
// Opcodes, field widths, register map and the pattern ROM.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int FREQ_W    = 12;
    localparam int GAIN_W    = 12;
    localparam int ELAPSED_W = 9;
    localparam int PAT_W     = 3;
    localparam int STEP_W    = 3;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [FREQ_W-1:0]    GAIN_BASE_HZ  = 12'd500;
    localparam logic [9:0]           GAIN_SCALE_HZ = 10'd1000;

    localparam logic REG_SOUND_ENABLE = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_GAIN = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic [FREQ_W-1:0]    hz;
        logic [ELAPSED_W-1:0] ms;
    } t_step;

    function automatic logic [STEP_W-1:0] rom_len(input logic [PAT_W-1:0] pat);
        logic [STEP_W-1:0] len;
        case (pat)
            3'd0:    len = 3'd5;
            3'd2:    len = 3'd1;
            3'd5:    len = 3'd5;
            default: len = 3'd3;
        endcase
        return len;
    endfunction

    function automatic t_step mk(input int hz, input int ms);
        t_step s;
        s.hz = FREQ_W'(hz);
        s.ms = ELAPSED_W'(ms);
        return s;
    endfunction

    function automatic t_step rom_step(input logic [PAT_W-1:0] pat,
                                       input logic [STEP_W-1:0] step);
        t_step s;
        s = mk(0, 0);
        case ({pat, step})
            {3'd0, 3'd0}: s = mk(1500, 80);
            {3'd0, 3'd1}: s = mk(0, 30);
            {3'd0, 3'd2}: s = mk(2000, 80);
            {3'd0, 3'd3}: s = mk(0, 30);
            {3'd0, 3'd4}: s = mk(2500, 80);
            {3'd1, 3'd0}: s = mk(1500, 100);
            {3'd1, 3'd1}: s = mk(0, 30);
            {3'd1, 3'd2}: s = mk(2500, 150);
            {3'd2, 3'd0}: s = mk(2000, 100);
            {3'd3, 3'd0}: s = mk(2000, 80);
            {3'd3, 3'd1}: s = mk(0, 50);
            {3'd3, 3'd2}: s = mk(2000, 80);
            {3'd4, 3'd0}: s = mk(2000, 80);
            {3'd4, 3'd1}: s = mk(0, 200);
            {3'd4, 3'd2}: s = mk(2500, 300);
            {3'd5, 3'd0}: s = mk(1500, 100);
            {3'd5, 3'd1}: s = mk(0, 50);
            {3'd5, 3'd2}: s = mk(2000, 100);
            {3'd5, 3'd3}: s = mk(0, 50);
            {3'd5, 3'd4}: s = mk(2500, 100);
            {3'd6, 3'd0}: s = mk(2500, 100);
            {3'd6, 3'd1}: s = mk(0, 50);
            {3'd6, 3'd2}: s = mk(1500, 100);
            {3'd7, 3'd0}: s = mk(800, 200);
            {3'd7, 3'd1}: s = mk(0, 100);
            {3'd7, 3'd2}: s = mk(800, 200);
            default:      s = mk(0, 0);
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/tps_gain_freq.sv =====
// ----------------------------------------------------------------------------
// Gain tone frequency
// 500 + (gain * 1000) >> 8 for unsigned Q4.8 gain, saturated at MAX_FREQ.
// ----------------------------------------------------------------------------
module tps_gain_freq #(
    parameter int MAX_FREQ = 4000
) (
    input  logic [tps_pkg::GAIN_W-1:0] i_gain,
    output logic [tps_pkg::FREQ_W-1:0] o_freq
);

    localparam int PROD_W = tps_pkg::GAIN_W + 10;
    localparam int SUM_W  = PROD_W - 8 + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;

    assign prod = PROD_W'(i_gain) * PROD_W'(tps_pkg::GAIN_SCALE_HZ);
    assign sum  = SUM_W'(prod[PROD_W-1:8]) + SUM_W'(tps_pkg::GAIN_BASE_HZ);

    always_comb begin
        if (sum > SUM_W'(MAX_FREQ)) begin
            o_freq = tps_pkg::FREQ_W'(MAX_FREQ);
        end else begin
            o_freq = sum[tps_pkg::FREQ_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/tone_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Tone pattern sequencer
// Plays ROM beep patterns and gain tones, advanced by millisecond tick items.
//
//   channel   dir  handshake                      contents
//   s_axis    in   s_axis_tvalid / s_axis_tready  opcode, pattern_id, gain
//   m_axis    out  m_axis_tvalid / m_axis_tready  tone_on, tone_freq, busy_res
//   apb       in   psel & penable & pwrite        sound_enable (addr 0)
//
// One item per cycle unless stalled: each accepted item updates the state
// and loads the result register in the same cycle; gain multiply and step
// ROM lookup sit between the input and state registers and the result
// register. Result appears in the cycle after acceptance; s_axis_tready
// stays high unless a result is waiting and m_axis_tready is low.
// Synchronous reset: idle, no result pending, sound_enable = 1.
// ----------------------------------------------------------------------------
module tone_pattern_sequencer #(
    parameter int GAIN_TONE_MS = 50,
    parameter int MAX_FREQ     = 4000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [2:0] pattern_id, [14:3] gain, [15] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] tone_on, [12:1] tone_freq, [13] busy_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FW = tps_pkg::FREQ_W;
    localparam int EW = tps_pkg::ELAPSED_W;
    localparam int PW = tps_pkg::PAT_W;
    localparam int SW = tps_pkg::STEP_W;

    logic          r_enable,    n_enable;
    logic          r_active,    n_active;
    logic          r_gain_mode, n_gain_mode;
    logic [PW-1:0] r_pattern,   n_pattern;
    logic [SW-1:0] r_step,      n_step;
    logic [EW-1:0] r_elapsed,   n_elapsed;
    logic          r_sounding,  n_sounding;
    logic [FW-1:0] r_freq,      n_freq;
    logic          r_out_valid;
    logic [15:0]   r_out_data,  n_out_data;

    logic             accept;
    logic             cfg_wr;
    tps_pkg::t_opcode opcode;
    logic [PW-1:0]    in_pattern;
    logic [FW-1:0]    gain_freq;
    logic [EW-1:0]    elapsed_inc;
    logic [SW-1:0]    step_inc;
    logic [SW-1:0]    cur_len;
    tps_pkg::t_step   cur_step;
    tps_pkg::t_step   next_step;
    tps_pkg::t_step   first_step;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign opcode        = tps_pkg::t_opcode'(s_axis_tuser);
    assign in_pattern    = s_axis_tdata[PW-1:0];

    tps_gain_freq #(
        .MAX_FREQ (MAX_FREQ)
    ) u_gain_freq (
        .i_gain (s_axis_tdata[PW +: tps_pkg::GAIN_W]),
        .o_freq (gain_freq)
    );

    assign elapsed_inc = (r_elapsed == tps_pkg::ELAPSED_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign step_inc    = r_step + 1'b1;
    assign cur_len     = tps_pkg::rom_len(r_pattern);
    assign cur_step    = tps_pkg::rom_step(r_pattern, r_step);
    assign next_step   = tps_pkg::rom_step(r_pattern, step_inc);
    assign first_step  = tps_pkg::rom_step(in_pattern, '0);

    always_comb begin
        n_enable    = r_enable;
        n_active    = r_active;
        n_gain_mode = r_gain_mode;
        n_pattern   = r_pattern;
        n_step      = r_step;
        n_elapsed   = r_elapsed;
        n_sounding  = r_sounding;
        n_freq      = r_freq;

        if (accept) begin
            case (opcode)
                tps_pkg::OP_TICK: begin
                    if (r_active) begin
                        n_elapsed = elapsed_inc;
                        if (r_gain_mode) begin
                            if (elapsed_inc >= EW'(GAIN_TONE_MS)) begin
                                n_active    = 1'b0;
                                n_gain_mode = 1'b0;
                                n_sounding  = 1'b0;
                                n_freq      = '0;
                            end
                        end else if (r_step >= cur_len) begin
                            n_active    = 1'b0;
                            n_gain_mode = 1'b0;
                            n_sounding  = 1'b0;
                            n_freq      = '0;
                        end else if (elapsed_inc >= cur_step.ms) begin
                            n_step = step_inc;
                            if (step_inc >= cur_len) begin
                                n_active    = 1'b0;
                                n_gain_mode = 1'b0;
                                n_sounding  = 1'b0;
                                n_freq      = '0;
                            end else begin
                                n_elapsed  = '0;
                                n_freq     = next_step.hz;
                                n_sounding = (next_step.hz != '0);
                            end
                        end
                    end
                end
                tps_pkg::OP_PLAY: begin
                    if (r_enable) begin
                        n_active    = 1'b1;
                        n_gain_mode = 1'b0;
                        n_pattern   = in_pattern;
                        n_step      = '0;
                        n_elapsed   = '0;
                        n_freq      = first_step.hz;
                        n_sounding  = (first_step.hz != '0);
                    end
                end
                tps_pkg::OP_GAIN: begin
                    if (r_enable) begin
                        n_active    = 1'b1;
                        n_gain_mode = 1'b1;
                        n_pattern   = '0;
                        n_step      = '0;
                        n_elapsed   = '0;
                        n_freq      = gain_freq;
                        n_sounding  = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cfg_wr && paddr[2] == tps_pkg::REG_SOUND_ENABLE) begin
            n_enable = pwdata[0];
            if (!pwdata[0]) begin
                n_active    = 1'b0;
                n_gain_mode = 1'b0;
                n_sounding  = 1'b0;
                n_freq      = '0;
            end
        end

        n_out_data = {2'b00, n_active, (n_sounding ? n_freq : FW'(0)), n_sounding};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_active    <= 1'b0;
            r_gain_mode <= 1'b0;
            r_pattern   <= '0;
            r_step      <= '0;
            r_elapsed   <= '0;
            r_sounding  <= 1'b0;
            r_freq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_enable    <= n_enable;
            r_active    <= n_active;
            r_gain_mode <= n_gain_mode;
            r_pattern   <= n_pattern;
            r_step      <= n_step;
            r_elapsed   <= n_elapsed;
            r_sounding  <= n_sounding;
            r_freq      <= n_freq;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == tps_pkg::REG_SOUND_ENABLE) ? {31'd0, r_enable} : '0;

endmodule

// ===== hw/rtl/tps_checker.sv =====
// ----------------------------------------------------------------------------
// Tone pattern sequencer checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "tone_pattern_sequencer_assert.svh"

module tps_checker #(
    parameter int MAX_FREQ = 4000
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    `TPS_ASSERT_ALWAYS(a_reset_clears_valid, i_clk,
        !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    `TPS_ASSERT(a_tone_needs_busy, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[13], "tone on while idle")
    `TPS_ASSERT(a_silent_zero_freq, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[12:1] == 12'd0,
        "nonzero frequency while silent")
    `TPS_ASSERT(a_freq_limit, i_clk, i_rst_n,
        m_axis_tvalid |-> m_axis_tdata[12:1] <= 12'(MAX_FREQ), "frequency above limit")
    `TPS_ASSERT(a_stall_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled item changed")

endmodule

bind tone_pattern_sequencer tps_checker #(
    .MAX_FREQ (MAX_FREQ)
) u_tps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
